>>> hdl/bgti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgti_pkg: shared types and constants
// Sizes, action codes, register indexes and fixed-point constants of the
// bilinear grid table interpolator.
// ---------------------------------------------------------------------------
package bgti_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 6;
  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 16;
  localparam int GRID_AW    = 2 * IDX_W;
  localparam int WGT_W      = 17;                 // Q0.16 plus one bit for 1.0
  localparam int PROD_W     = 2 * WGT_W - 1;      // weight product, at most 2^32
  localparam int ACC_W      = PROD_W + VALUE_BITS + 2;
  localparam int DIV_CNT_W  = $clog2(WGT_W + 1);

  localparam logic [WGT_W-1:0] ONE_W = WGT_W'(1) << 16;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 31;

  // regression coefficients, Q.16 scaled
  localparam logic [29:0] REG_K0 = 30'd705031045;
  localparam logic [14:0] REG_KX = 15'd31326;
  localparam logic [13:0] REG_KY = 14'd15622;
  localparam int REG_W = 35;

  typedef enum logic [1:0] {
    ACT_LOAD_X = 2'd0,
    ACT_LOAD_Y = 2'd1,
    ACT_LOAD_G = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_X_POINTS = 2'd0,
    REG_Y_POINTS = 2'd1,
    REG_MODE     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      ci;
    logic [IDX_W-1:0]      cj;
    logic [COORD_BITS-1:0] x_lo;
    logic [COORD_BITS-1:0] x_hi;
    logic [COORD_BITS-1:0] y_lo;
    logic [COORD_BITS-1:0] y_hi;
  } srch_t;

endpackage

>>> hdl/bgti_axis.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgti_axis: axis tables and cell search
// Holds both axis tables and finds the highest containing cell on each axis
// with one comparator pair per cell.
// ---------------------------------------------------------------------------
module bgti_axis import bgti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  x_we_i,
  input  logic                  y_we_i,
  input  logic [IDX_W-1:0]      x_idx_i,
  input  logic [IDX_W-1:0]      y_idx_i,
  input  logic [COORD_BITS-1:0] wdata_i,
  input  logic [CNT_W-1:0]      x_points_i,
  input  logic [CNT_W-1:0]      y_points_i,
  input  logic [COORD_BITS-1:0] qx_i,
  input  logic [COORD_BITS-1:0] qy_i,
  output srch_t                 srch_o
);

  logic [COORD_BITS-1:0] x_axis_q [MAX_POINTS];
  logic [COORD_BITS-1:0] y_axis_q [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (x_we_i) begin
      x_axis_q[x_idx_i] <= wdata_i;
    end
    if (y_we_i) begin
      y_axis_q[y_idx_i] <= wdata_i;
    end
  end

  logic [CNT_W:0] nx, ny;
  logic           hx, hy;
  logic [IDX_W-1:0] ix, iy;

  always_comb begin
    nx = (x_points_i > CNT_W'(MAX_POINTS)) ? (CNT_W+1)'(MAX_POINTS) : {1'b0, x_points_i};
    ny = (y_points_i > CNT_W'(MAX_POINTS)) ? (CNT_W+1)'(MAX_POINTS) : {1'b0, y_points_i};
    hx = 1'b0;
    hy = 1'b0;
    ix = '0;
    iy = '0;
    // ascending scan: the last match is the highest index
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (((CNT_W+1)'(i) + (CNT_W+1)'(2) <= nx) &&
          qx_i >= x_axis_q[i] && qx_i <= x_axis_q[i+1]) begin
        hx = 1'b1;
        ix = IDX_W'(i);
      end
      if (((CNT_W+1)'(i) + (CNT_W+1)'(2) <= ny) &&
          qy_i >= y_axis_q[i] && qy_i <= y_axis_q[i+1]) begin
        hy = 1'b1;
        iy = IDX_W'(i);
      end
    end
    srch_o.hit  = hx & hy;
    srch_o.ci   = ix;
    srch_o.cj   = iy;
    srch_o.x_lo = x_axis_q[ix];
    srch_o.x_hi = x_axis_q[ix + IDX_W'(1)];
    srch_o.y_lo = y_axis_q[iy];
    srch_o.y_hi = y_axis_q[iy + IDX_W'(1)];
  end

endmodule

>>> hdl/bgti_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgti_div: weight divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den where
// num <= den. A zero span gives a zero weight.
// ---------------------------------------------------------------------------
module bgti_div import bgti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] num_i,
  input  logic [COORD_BITS-1:0] den_i,
  output logic                  done_o,
  output logic [WGT_W-1:0]      quo_o
);

  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q;
  logic [WGT_W-1:0]      quo_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  ge;
  logic [COORD_BITS:0]   diff;

  always_comb begin
    ge    = rem_q >= {1'b0, den_q};
    diff  = rem_q - {1'b0, den_q};
    rem_d = ge ? {diff[COORD_BITS-1:0], 1'b0} : {rem_q[COORD_BITS-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(WGT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[WGT_W-2:0], ge};
    end
  end

  assign quo_o = (den_q == '0) ? '0 : quo_q;

endmodule

>>> hdl/bgti_grid_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgti_grid_ram: grid value memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bgti_grid_ram import bgti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [GRID_AW-1:0]    waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [GRID_AW-1:0]    raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem [MAX_POINTS*MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/bilinear_grid_table_interpolator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_grid_table_interpolator_top: grid table interpolator
// Axis search, weight division, four corner reads and blend of one query,
// or a linear regression of the query point when mode is set.
//   channel   signals                                    direction
//   command   start/busy, action_i .. query_y_i           in
//   result    done_o, interp_value_o, found_o             out (one cycle)
//   config    psel/penable/pwrite/paddr/pwdata/prdata     APB
//
// Loads keep busy low. After a table query is accepted busy stays high
// through the search, one divider step per weight bit, the divider done flag,
// then a read and an accumulate state per corner on the single grid read port;
// a query that hits no cell ends after the search. A regression query keeps
// busy high through ST_REG1 and ST_REG2. The result word is on the ports in
// the cycle in which busy drops. Reset sets x_points and y_points to 2 and
// mode to 0; tables are not cleared. The result strobe cannot be stalled.
// ---------------------------------------------------------------------------
module bilinear_grid_table_interpolator_top import bgti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [IDX_W-1:0]      row_index_i,
  input  logic [IDX_W-1:0]      col_index_i,
  input  logic [COORD_BITS-1:0] load_value_i,
  input  logic [COORD_BITS-1:0] query_x_i,
  input  logic [COORD_BITS-1:0] query_y_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] interp_value_o,
  output logic                  found_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRCH, ST_DIV, ST_RD, ST_ACC, ST_REG1, ST_REG2
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      x_points_q, y_points_q;
  logic                  mode_q;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  srch_t                 srch_c, srch_q;
  logic [1:0]            k_q;
  logic [PROD_W-1:0]     wprod_q;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [31:0]           px_q;
  logic                  accept, cfg_we, div_start, div_done;
  logic [WGT_W-1:0]      t_w, u_w, wa, wb;
  logic [IDX_W-1:0]      rd_row, rd_col;
  logic [VALUE_BITS-1:0] rdata;
  logic signed [REG_W-1:0] reg_v;
  logic [REG_W-1:0]      reg_r;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start & ~busy;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_X_POINTS: prdata = 32'(x_points_q);
      REG_Y_POINTS: prdata = 32'(y_points_q);
      REG_MODE:     prdata = 32'(mode_q);
      default:      prdata = '0;
    endcase
  end

  bgti_axis u_axis (
    .clk_i      (clk_i),
    .x_we_i     (accept && action_i == ACT_LOAD_X),
    .y_we_i     (accept && action_i == ACT_LOAD_Y),
    .x_idx_i    (row_index_i),
    .y_idx_i    (col_index_i),
    .wdata_i    (load_value_i),
    .x_points_i (x_points_q),
    .y_points_i (y_points_q),
    .qx_i       (qx_q),
    .qy_i       (qy_q),
    .srch_o     (srch_c)
  );

  assign div_start = (state_q == ST_SRCH) && srch_c.hit;

  bgti_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (qx_q - srch_c.x_lo),
    .den_i   (srch_c.x_hi - srch_c.x_lo),
    .done_o  (div_done),
    .quo_o   (t_w)
  );

  // same latency as the x divider; both strobes rise together
  logic div_y_done;
  bgti_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (qy_q - srch_c.y_lo),
    .den_i   (srch_c.y_hi - srch_c.y_lo),
    .done_o  (div_y_done),
    .quo_o   (u_w)
  );

  // corner order: (i,j) (i+1,j) (i+1,j+1) (i,j+1)
  always_comb begin
    wa     = (k_q == 2'd0 || k_q == 2'd3) ? ONE_W - t_w : t_w;
    wb     = (k_q == 2'd0 || k_q == 2'd1) ? ONE_W - u_w : u_w;
    rd_row = (k_q == 2'd1 || k_q == 2'd2) ? srch_q.ci + IDX_W'(1) : srch_q.ci;
    rd_col = (k_q == 2'd2 || k_q == 2'd3) ? srch_q.cj + IDX_W'(1) : srch_q.cj;
    acc_d  = acc_q + ACC_W'(wprod_q) * ACC_W'(rdata);
    reg_v  = $signed({5'b0, REG_K0}) - $signed({3'b0, px_q})
           - $signed(REG_W'(REG_KY) * REG_W'(qy_q));
    reg_r  = REG_W'(reg_v + REG_W'(32768)) >> 16;
  end

  bgti_grid_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && action_i == ACT_LOAD_G),
    .waddr_i ({row_index_i, col_index_i}),
    .wdata_i (load_value_i),
    .raddr_i ({rd_row, rd_col}),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      x_points_q <= CNT_W'(2);
      y_points_q <= CNT_W'(2);
      mode_q     <= 1'b0;
      done_o     <= 1'b0;
      k_q        <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_X_POINTS: x_points_q <= pwdata[CNT_W-1:0];
          REG_Y_POINTS: y_points_q <= pwdata[CNT_W-1:0];
          REG_MODE:     mode_q     <= pwdata[0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && action_i == ACT_QUERY) begin
            state_q <= mode_q ? ST_REG1 : ST_SRCH;
          end
        end
        ST_SRCH: begin
          k_q <= '0;
          if (srch_c.hit) begin
            state_q <= ST_DIV;
          end else begin
            done_o  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done && div_y_done) begin
            state_q <= ST_RD;
          end
        end
        ST_RD:  state_q <= ST_ACC;
        ST_ACC: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            done_o  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_RD;
          end
        end
        ST_REG1: state_q <= ST_REG2;
        ST_REG2: begin
          done_o  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
    end
    unique case (state_q)
      ST_SRCH: begin
        srch_q         <= srch_c;
        acc_q          <= ROUND_HALF;   // rounding folded into the start value
        interp_value_o <= '0;
        found_o        <= 1'b0;
      end
      ST_RD:  wprod_q <= PROD_W'(wa) * PROD_W'(wb);
      ST_ACC: begin
        acc_q <= acc_d;
        if (k_q == 2'd3) begin
          interp_value_o <= acc_d[32 +: VALUE_BITS];
          found_o        <= 1'b1;
        end
      end
      ST_REG1: px_q <= 32'(REG_KX) * 32'(qx_q);
      ST_REG2: begin
        found_o <= 1'b1;
        if (reg_v < 0) begin
          interp_value_o <= '0;
        end else if (reg_r > REG_W'({VALUE_BITS{1'b1}})) begin
          interp_value_o <= '1;
        end else begin
          interp_value_o <= reg_r[VALUE_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> test/bgti_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgti_checker: result predictor and scoreboard
// Watches the command, result and register ports of the grid interpolator.
// It keeps its own copy of the axis tables, the grid and the registers,
// predicts the answer of each accepted query, and compares every result
// word in order.
// ---------------------------------------------------------------------------
module bgti_checker import bgti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [1:0]            action_i,
  input  logic [IDX_W-1:0]      row_index_i,
  input  logic [IDX_W-1:0]      col_index_i,
  input  logic [COORD_BITS-1:0] load_value_i,
  input  logic [COORD_BITS-1:0] query_x_i,
  input  logic [COORD_BITS-1:0] query_y_i,
  input  logic                  done_i,
  input  logic [VALUE_BITS-1:0] interp_value_i,
  input  logic                  found_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [3:0]            paddr_i,
  input  logic [31:0]           pwdata_i,
  output int                    mismatches_o,
  output int                    answers_due_o,
  output int                    answers_seen_o
);

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  found;
  } answer_t;

  logic [COORD_BITS-1:0] x_tab [MAX_POINTS];
  logic [COORD_BITS-1:0] y_tab [MAX_POINTS];
  logic [VALUE_BITS-1:0] grid  [MAX_POINTS*MAX_POINTS];
  logic [CNT_W-1:0]      x_cnt = 2;
  logic [CNT_W-1:0]      y_cnt = 2;
  logic                  regr  = 1'b0;
  answer_t               answers_due [$];

  initial begin
    mismatches_o   = 0;
    answers_seen_o = 0;
  end

  assign answers_due_o = answers_due.size();

  task automatic report(string what, int want, int got);
    $display("%0t: MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches_o++;
  endtask

  function automatic longint unsigned span_weight(longint unsigned q, longint unsigned lo,
                                                  longint unsigned hi);
    if (hi == lo) return 0;
    return ((q - lo) << 16) / (hi - lo);
  endfunction

  function automatic answer_t interpolate(logic [COORD_BITS-1:0] qx,
                                          logic [COORD_BITS-1:0] qy);
    answer_t         a;
    int              nx, ny, ci, cj;
    bit              hit;
    longint          lin;
    longint unsigned t, u, one, acc;
    a.value = '0;
    a.found = 1'b0;
    hit = 0;
    ci = 0;
    cj = 0;
    one = 65536;
    if (regr) begin
      lin = 64'sd705031045 - 64'sd31326 * longint'(qx) - 64'sd15622 * longint'(qy);
      if (lin < 0) a.value = '0;
      else if (((lin + 32768) >>> 16) > 65535) a.value = '1;
      else a.value = VALUE_BITS'((lin + 32768) >>> 16);
      a.found = 1'b1;
      return a;
    end
    nx = (x_cnt > MAX_POINTS) ? MAX_POINTS : x_cnt;
    ny = (y_cnt > MAX_POINTS) ? MAX_POINTS : y_cnt;
    for (int i = 0; i + 1 < nx; i++) begin
      if (qx >= x_tab[i] && qx <= x_tab[i+1]) begin
        for (int j = 0; j + 1 < ny; j++) begin
          if (qy >= y_tab[j] && qy <= y_tab[j+1]) begin
            hit = 1;
            ci = i;
            cj = j;
          end
        end
      end
    end
    if (!hit) return a;
    t = span_weight(qx, x_tab[ci], x_tab[ci+1]);
    u = span_weight(qy, y_tab[cj], y_tab[cj+1]);
    acc = (one - t) * (one - u) * grid[ci*MAX_POINTS + cj]
        + t * (one - u) * grid[(ci+1)*MAX_POINTS + cj]
        + t * u * grid[(ci+1)*MAX_POINTS + cj + 1]
        + (one - t) * u * grid[ci*MAX_POINTS + cj + 1];
    acc = (acc + (64'd1 << 31)) >> 32;
    a.value = VALUE_BITS'(acc);
    a.found = 1'b1;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      x_cnt = 2;
      y_cnt = 2;
      regr  = 1'b0;
      answers_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_X_POINTS: x_cnt = pwdata_i[CNT_W-1:0];
          REG_Y_POINTS: y_cnt = pwdata_i[CNT_W-1:0];
          REG_MODE:     regr  = pwdata_i[0];
          default: ;
        endcase
      end
      if (done_i) begin
        answers_seen_o++;
        if (answers_due.size() == 0) begin
          report("unexpected result word, value", 0, interp_value_i);
        end else begin
          want = answers_due.pop_front();
          if (interp_value_i !== want.value) report("interp_value", want.value, interp_value_i);
          if (found_i !== want.found) report("found", want.found, found_i);
        end
      end
      if (start_i && !busy_i) begin
        case (action_e'(action_i))
          ACT_LOAD_X: x_tab[row_index_i] = load_value_i;
          ACT_LOAD_Y: y_tab[col_index_i] = load_value_i;
          ACT_LOAD_G: grid[row_index_i*MAX_POINTS + col_index_i] = load_value_i;
          ACT_QUERY:  answers_due.push_back(interpolate(query_x_i, query_y_i));
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: grid interpolator testbench
// Loads axis tables and grids of many sizes, issues table and regression
// queries with random gaps, and lets the checker score every result word.
// ---------------------------------------------------------------------------
module tb;
  import bgti_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action = '0;
  logic [IDX_W-1:0]      row_idx = '0;
  logic [IDX_W-1:0]      col_idx = '0;
  logic [COORD_BITS-1:0] load_val = '0;
  logic [COORD_BITS-1:0] qx = '0;
  logic [COORD_BITS-1:0] qy = '0;
  logic                  done;
  logic [VALUE_BITS-1:0] interp_value;
  logic                  found;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [3:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    mismatches, answers_due, answers_seen;

  logic [COORD_BITS-1:0] x_axis_copy [MAX_POINTS];
  logic [COORD_BITS-1:0] y_axis_copy [MAX_POINTS];
  int                    queries = 0;
  int                    items = 0;
  int                    phases = 0;
  bit                    no_gaps = 0;

  initial forever #1 clk = ~clk;

  bilinear_grid_table_interpolator_top i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .action_i(action), .row_index_i(row_idx), .col_index_i(col_idx),
    .load_value_i(load_val), .query_x_i(qx), .query_y_i(qy),
    .done_o(done), .interp_value_o(interp_value), .found_o(found),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bgti_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .action_i(action), .row_index_i(row_idx), .col_index_i(col_idx),
    .load_value_i(load_val), .query_x_i(qx), .query_y_i(qy),
    .done_i(done), .interp_value_i(interp_value), .found_i(found),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .mismatches_o(mismatches),
    .answers_due_o(answers_due), .answers_seen_o(answers_seen)
  );

  initial begin
    #4ms;
    $display("timeout");
    $display("bilinear_grid_table_interpolator_top verification failed");
    $finish;
  end

  // returns in the time step of the accepting edge
  task automatic send(action_e a, int r, int c, int lv, int x, int y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    action   <= a;
    row_idx  <= IDX_W'(r);
    col_idx  <= IDX_W'(c);
    load_val <= COORD_BITS'(lv);
    qx       <= COORD_BITS'(x);
    qy       <= COORD_BITS'(y);
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
    if (a == ACT_QUERY) queries++;
    if (a == ACT_LOAD_X) x_axis_copy[r] = COORD_BITS'(lv);
    if (a == ACT_LOAD_Y) y_axis_copy[c] = COORD_BITS'(lv);
  endtask

  task automatic load(action_e a, int r, int c, int lv);
    send(a, r, c, lv, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic ask(int x, int y);
    send(ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
         $urandom_range(0, 65535), x, y);
  endtask

  // idle the command side, drain results, let a silent query finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic fill_axis(action_e a, int n, bit full_span);
    int v;
    v = full_span ? 0 : $urandom_range(0, 20000);
    for (int k = 0; k < n; k++) begin
      if (full_span && k == n - 1) v = 65535;
      if (a == ACT_LOAD_X) load(a, k, $urandom_range(0, 31), v);
      else load(a, $urandom_range(0, 31), k, v);
      if ($urandom_range(0, 7) != 0) v = v + $urandom_range(1, 1400);
      if (v > 65535) v = 65535;
    end
  endtask

  function automatic int pick_coord(logic [COORD_BITS-1:0] tab [MAX_POINTS], int n);
    int sel;
    sel = $urandom_range(0, 9);
    if (n < 2 || sel < 2) return $urandom_range(0, 65535);
    if (sel < 4) return tab[$urandom_range(0, n - 1)];
    if (tab[n-1] >= tab[0]) return $urandom_range(tab[0], tab[n-1]);
    return $urandom_range(tab[n-1], tab[0]);
  endfunction

  task automatic run_phase(int cx, int cy, bit regression, int nq);
    int nx, ny, sel;
    settle();
    phases++;
    no_gaps = ($urandom_range(0, 3) == 0);
    reg_write(REG_X_POINTS, cx);
    reg_write(REG_Y_POINTS, cy);
    reg_write(REG_MODE, regression);
    // the unused index must be harmless
    if ($urandom_range(0, 3) == 0) reg_write(REG_NONE, $urandom);
    nx = (cx > MAX_POINTS) ? MAX_POINTS : cx;
    ny = (cy > MAX_POINTS) ? MAX_POINTS : cy;
    if (!regression) begin
      sel = ($urandom_range(0, 3) == 0);
      fill_axis(ACT_LOAD_X, nx, sel);
      fill_axis(ACT_LOAD_Y, ny, sel);
      if (nx >= 2 && ny >= 2)
        for (int r = 0; r < nx; r++)
          for (int c = 0; c < ny; c++)
            load(ACT_LOAD_G, r, c,
                 ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 65535));
    end
    for (int k = 0; k < nq; k++) begin
      if ($urandom_range(0, 9) == 0)
        load(action_e'($urandom_range(0, 2)), $urandom_range(0, 31),
             $urandom_range(0, 31), $urandom_range(0, 65535));
      else if (regression)
        ask($urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        ask(pick_coord(x_axis_copy, nx), pick_coord(y_axis_copy, ny));
    end
  endtask

  initial begin
    int cx, cy;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sizes, full-range corners
    load(ACT_LOAD_X, 0, 0, 0);
    load(ACT_LOAD_X, 1, 0, 65535);
    load(ACT_LOAD_Y, 0, 0, 0);
    load(ACT_LOAD_Y, 0, 1, 65535);
    load(ACT_LOAD_G, 0, 0, 65535);
    load(ACT_LOAD_G, 1, 0, 0);
    load(ACT_LOAD_G, 1, 1, 65535);
    load(ACT_LOAD_G, 0, 1, 0);
    ask(0, 0);
    ask(65535, 65535);
    ask(32768, 32768);
    ask(65535, 0);
    // zero-width span on x
    load(ACT_LOAD_X, 1, 0, 0);
    ask(0, 1000);
    // point outside every cell
    load(ACT_LOAD_X, 0, 0, 100);
    load(ACT_LOAD_X, 1, 0, 200);
    ask(50, 50);
    ask(65535, 65535);

    run_phase(2, 2, 1, 0);
    ask(0, 0);
    ask(65535, 65535);
    ask(0, 65535);
    run_phase(0, 5, 0, 6);
    run_phase(1, 1, 0, 6);
    run_phase(3, 0, 0, 6);
    run_phase(63, 2, 0, 30);
    run_phase(2, 32, 0, 30);
    run_phase(40, 4, 0, 25);

    while (items < 950) begin
      case ($urandom_range(0, 7))
        0: begin cx = $urandom_range(2, 63); cy = $urandom_range(2, 3); end
        1: begin cx = $urandom_range(2, 3); cy = $urandom_range(2, 63); end
        2: begin cx = $urandom_range(0, 1); cy = $urandom_range(0, 6); end
        default: begin cx = $urandom_range(2, 5); cy = $urandom_range(2, 5); end
      endcase
      run_phase(cx, cy, $urandom_range(0, 4) == 0, $urandom_range(20, 60));
    end
    settle();

    $display("%0d command words, %0d of them queries, over %0d register settings",
             items, queries, phases);
    $display("%0d result words checked", answers_seen);
    if (mismatches == 0 && answers_due == 0) begin
      $display("bilinear_grid_table_interpolator_top verification clean");
    end else begin
      $display("bilinear_grid_table_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bgti_pkg.sv
hdl/bgti_axis.sv
hdl/bgti_div.sv
hdl/bgti_grid_ram.sv
hdl/bilinear_grid_table_interpolator_top.sv
test/bgti_checker.sv
test/tb.sv
